### hdl/rtps_pkg.sv
// Package for the RTP receive statistics block: opcodes, constants and the
// command/status structs between the controller and the datapath.
// No dependencies.
package rtps_pkg;

  typedef enum logic [1:0] {
    OP_INIT   = 2'd0,
    OP_PACKET = 2'd1,
    OP_STATS  = 2'd2
  } op_t;

  localparam logic [23:0] CUM_LOST_MAX = 24'hFFFFFF;
  localparam logic [7:0]  FRACTION_MAX = 8'hFF;

  // One quotient bit of the fraction is produced per divide step.
  localparam int DIV_STEPS = 8;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  typedef struct packed {
    logic capture;
    logic init;
    logic pkt1;
    logic pkt2;
    logic pkt3;
    logic pkt4;
    logic pkt5;
    logic st1;
    logic st2;
    logic st3;
    logic st4;
    logic div_step;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       div_needed;
    logic       out_busy;
  } status_t;

endpackage

### hdl/rtps_in_if.sv
// Input channel of the RTP receive statistics block: valid/ready and the
// item payload. No dependencies.
interface rtps_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [15:0] seq_no;
  logic [31:0] media_timestamp;
  logic [31:0] arrival_time;
  logic        keep_interval;

  modport source (output valid, op, seq_no, media_timestamp, arrival_time, keep_interval,
                  input ready);
  modport sink   (input valid, op, seq_no, media_timestamp, arrival_time, keep_interval,
                  output ready);
endinterface

### hdl/rtps_out_if.sv
// Result channel of the RTP receive statistics block: valid/ready and the
// report payload. No dependencies.
interface rtps_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  fraction_lost;
  logic [23:0] cumulative_lost;
  logic [31:0] extended_max_seq;
  logic [31:0] jitter_estimate;

  modport source (output valid, fraction_lost, cumulative_lost, extended_max_seq,
                  jitter_estimate, input ready);
  modport sink   (input valid, fraction_lost, cumulative_lost, extended_max_seq,
                  jitter_estimate, output ready);
endinterface

### hdl/rtp_receiver_stats.sv
// Top level of the RTP receive statistics block: controller and datapath.
// Depends on rtps_pkg, rtps_in_if, rtps_out_if, rtps_ctrl and rtps_dp.
//
//   Channel   Role   Transaction
//   item      sink   one operation: init, packet or stats read
//   result    source one report, produced by each stats read only
//
// An item is taken only while the sequencer is idle. Init passes through
// dispatch only, a packet through five dependent 32-bit steps of the jitter
// update, and a stats read through its steps and, unless the fraction is zero
// or clamped, the 8-step restoring divider that forms the fraction one bit a cycle.
// Reset is synchronous and clears all stream state at once.
// The result register holds a report until it is taken; a stats read that
// finishes while the previous report still waits stalls in its last step.
module rtp_receiver_stats (
  input  logic        clk,
  input  logic        rst,
  rtps_in_if.sink     item,
  rtps_out_if.source  result
);

  rtps_pkg::cmd_t    cmd;
  rtps_pkg::status_t status;
  logic              ready;

  assign item.ready = ready;

  rtps_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item.valid),
    .item_ready (ready),
    .status     (status),
    .cmd        (cmd)
  );

  rtps_dp u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .status          (status),
    .op              (item.op),
    .seq_no          (item.seq_no),
    .media_timestamp (item.media_timestamp),
    .arrival_time    (item.arrival_time),
    .keep_interval   (item.keep_interval),
    .result          (result)
  );

endmodule

### hdl/rtps_ctrl.sv
// Sequencer of the RTP receive statistics block: steps the datapath through
// init, packet and stats operations. Depends on rtps_pkg.
module rtps_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_ready,
  input  rtps_pkg::status_t  status,
  output rtps_pkg::cmd_t     cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_PKT1,
    S_PKT2,
    S_PKT3,
    S_PKT4,
    S_PKT5,
    S_ST1,
    S_ST2,
    S_ST3,
    S_ST4,
    S_DIV,
    S_OUT
  } state_t;

  state_t                          state;
  logic [rtps_pkg::DIV_CNT_W-1:0]  cnt;

  assign item_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (item_valid) state <= S_DISPATCH;
        end
        S_DISPATCH: begin
          unique case (status.op)
            rtps_pkg::OP_PACKET: state <= S_PKT1;
            rtps_pkg::OP_STATS:  state <= S_ST1;
            default:             state <= S_IDLE;
          endcase
        end
        S_PKT1: state <= S_PKT2;
        S_PKT2: state <= S_PKT3;
        S_PKT3: state <= S_PKT4;
        S_PKT4: state <= S_PKT5;
        S_PKT5: state <= S_IDLE;
        S_ST1:  state <= S_ST2;
        S_ST2:  state <= S_ST3;
        S_ST3:  state <= S_ST4;
        S_ST4: begin
          cnt <= '0;
          if (status.div_needed) state <= S_DIV;
          else                   state <= S_OUT;
        end
        S_DIV: begin
          cnt <= cnt + 1'b1;
          if (cnt == rtps_pkg::DIV_CNT_W'(rtps_pkg::DIV_STEPS - 1)) state <= S_OUT;
        end
        S_OUT: begin
          if (!status.out_busy) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd          = '0;
    cmd.capture  = item_valid && item_ready;
    unique case (state)
      S_DISPATCH: cmd.init     = (status.op == rtps_pkg::OP_INIT);
      S_PKT1:     cmd.pkt1     = 1'b1;
      S_PKT2:     cmd.pkt2     = 1'b1;
      S_PKT3:     cmd.pkt3     = 1'b1;
      S_PKT4:     cmd.pkt4     = 1'b1;
      S_PKT5:     cmd.pkt5     = 1'b1;
      S_ST1:      cmd.st1      = 1'b1;
      S_ST2:      cmd.st2      = 1'b1;
      S_ST3:      cmd.st3      = 1'b1;
      S_ST4:      cmd.st4      = 1'b1;
      S_DIV:      cmd.div_step = 1'b1;
      S_OUT:      cmd.load_out = !status.out_busy;
      default:    cmd.capture  = item_valid && item_ready;
    endcase
  end

endmodule

### hdl/rtps_dp.sv
// Datapath of the RTP receive statistics block: stream state, jitter update,
// loss arithmetic, fraction divider and the result register.
// Depends on rtps_pkg and rtps_out_if.
module rtps_dp (
  input  logic               clk,
  input  logic               rst,
  input  rtps_pkg::cmd_t     cmd,
  output rtps_pkg::status_t  status,
  input  logic [1:0]         op,
  input  logic [15:0]        seq_no,
  input  logic [31:0]        media_timestamp,
  input  logic [31:0]        arrival_time,
  input  logic               keep_interval,
  rtps_out_if.source         result
);

  // Captured item.
  logic [1:0]  op_r;
  logic [15:0] seq_r;
  logic [31:0] ts_r;
  logic [31:0] arr_r;
  logic        keep_r;

  // Stream state.
  logic [15:0] base_sequence;
  logic [15:0] highest_sequence;
  logic [15:0] wrap_count;
  logic [31:0] received_count;
  logic [31:0] last_transit;
  logic [31:0] jitter_scaled;
  logic [31:0] expected_snapshot;
  logic [31:0] received_snapshot;

  // Intermediate results.
  logic [31:0] arr_minus_ts;
  logic [31:0] transit_new;
  logic [31:0] d_val;
  logic [31:0] a_val;
  logic [31:0] diff8;
  logic [31:0] expected;
  logic [31:0] cum_raw;
  logic        cum_pos;
  logic [31:0] exp_int;
  logic [31:0] rec_int;
  logic [31:0] lost;
  logic [23:0] cum_sat;
  logic [31:0] rem;
  logic [7:0]  frac;

  // Result register.
  logic        out_valid;
  logic [7:0]  out_frac;
  logic [23:0] out_cum;
  logic [31:0] out_ext;
  logic [31:0] out_jit;

  logic [15:0] d16;
  logic [31:0] ext_seq;
  logic        frac_zero;
  logic        frac_clamp;
  logic [32:0] rem2;
  logic [32:0] rem_sub;
  logic        rem_ge;

  assign d16     = seq_r - highest_sequence;
  assign ext_seq = {wrap_count, highest_sequence};

  assign frac_zero  = (exp_int == 32'd0) || (lost == 32'd0) || lost[31] ||
                      (received_count == 32'd0);
  // A quotient of 256 or more happens exactly when lost is not below exp_int.
  assign frac_clamp = (lost >= exp_int);

  assign rem2    = {rem, 1'b0};
  assign rem_sub = rem2 - {1'b0, exp_int};
  assign rem_ge  = (rem2 >= {1'b0, exp_int});

  assign status.op         = op_r;
  assign status.div_needed = !frac_zero && !frac_clamp;
  assign status.out_busy   = out_valid && !result.ready;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r   <= op;
      seq_r  <= seq_no;
      ts_r   <= media_timestamp;
      arr_r  <= arrival_time;
      keep_r <= keep_interval;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.init) begin
      base_sequence     <= rst ? 16'd0 : seq_r;
      highest_sequence  <= rst ? 16'd0 : seq_r;
      wrap_count        <= '0;
      received_count    <= '0;
      last_transit      <= '0;
      jitter_scaled     <= '0;
      expected_snapshot <= '0;
      received_snapshot <= '0;
    end else begin
      if (cmd.pkt1) begin
        received_count <= received_count + 32'd1;
        if (!d16[15]) begin
          if (seq_r < highest_sequence) wrap_count <= wrap_count + 16'd1;
          highest_sequence <= seq_r;
        end
      end
      if (cmd.pkt2) last_transit <= transit_new;
      // The first packet of a stream only sets the transit reference.
      if (cmd.pkt5 && (received_count[31:1] != 31'd0)) begin
        jitter_scaled <= jitter_scaled + {{4{diff8[31]}}, diff8[31:4]};
      end
      if (cmd.st2 && !keep_r) begin
        expected_snapshot <= expected;
        received_snapshot <= received_count;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pkt1) begin
      arr_minus_ts <= arr_r - ts_r;
      transit_new  <= ts_r - arr_r;
    end
    if (cmd.pkt2) d_val <= arr_minus_ts + last_transit;
    if (cmd.pkt3) a_val <= d_val[31] ? (32'd0 - d_val) : d_val;
    // The low nibble of 16*|D| is zero, so the rounding constant is an OR.
    if (cmd.pkt4) diff8 <= {a_val[27:0], 4'b1000} - jitter_scaled;
    if (cmd.st1) expected <= ext_seq - {16'd0, base_sequence} + 32'd1;
    if (cmd.st2) begin
      cum_raw <= expected - received_count;
      cum_pos <= (received_count != 32'd0) && (expected > received_count);
      exp_int <= expected - expected_snapshot;
      rec_int <= received_count - received_snapshot;
    end
    if (cmd.st3) begin
      lost    <= exp_int - rec_int;
      cum_sat <= !cum_pos ? 24'd0 :
                 (cum_raw[31:24] != 8'd0) ? rtps_pkg::CUM_LOST_MAX : cum_raw[23:0];
    end
    if (cmd.st4) begin
      rem  <= lost;
      frac <= (!frac_zero && frac_clamp) ? rtps_pkg::FRACTION_MAX : 8'd0;
    end
    if (cmd.div_step) begin
      rem  <= rem_ge ? rem_sub[31:0] : rem2[31:0];
      frac <= {frac[6:0], rem_ge};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_frac <= frac;
      out_cum  <= cum_sat;
      out_ext  <= ext_seq;
      out_jit  <= {4'd0, jitter_scaled[31:4]};
    end
  end

  assign result.valid            = out_valid;
  assign result.fraction_lost    = out_frac;
  assign result.cumulative_lost  = out_cum;
  assign result.extended_max_seq = out_ext;
  assign result.jitter_estimate  = out_jit;

endmodule

### sim/tb_rtp_receiver_stats.sv
// Self-checking testbench for rtp_receiver_stats: directed table, then random RTP streams.
// Depends on rtps_pkg, rtps_in_if, rtps_out_if and the rtp_receiver_stats RTL.
// Each report is checked field by field against the directed table's report or an in-bench model.
module tb_rtp_receiver_stats;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int DIRECTED_LEN  = 24;
  localparam int RANDOM_ITEMS  = 1050;
  localparam int QUIET_FROM    = DIRECTED_LEN + RANDOM_ITEMS - 150;
  localparam int STRIDE_ITEMS  = 640;
  localparam int CYCLE_LIMIT   = 500000;
  localparam int DRAIN_CYCLES  = 40;

  typedef struct packed {
    logic [7:0]  fraction_lost;
    logic [23:0] cumulative_lost;
    logic [31:0] extended_max_seq;
    logic [31:0] jitter_estimate;
  } report_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] seq;
    logic [31:0] ts;
    logic [31:0] arr;
    logic        keep;
    logic        typed;
    report_t     rep;
  } step_t;

  // Rows with typed = 1 carry a report that is obvious from the stream state;
  // the others are checked against the model below.
  localparam step_t DIRECTED [0:DIRECTED_LEN-1] = '{
    '{rtps_pkg::OP_STATS,  16'h0000, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b1,
      '{8'h00, 24'h000000, 32'h0000_0000, 32'h0000_0000}},
    '{OP_UNUSED,           16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b0, '0},
    '{rtps_pkg::OP_INIT,   16'hFFFF, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0, '0},
    '{rtps_pkg::OP_STATS,  16'h0000, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b1,
      '{8'h00, 24'h000000, 32'h0000_FFFF, 32'h0000_0000}},
    '{rtps_pkg::OP_PACKET, 16'hFFFF, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0, 1'b0, '0},
    '{rtps_pkg::OP_PACKET, 16'h0000, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0, 1'b0, '0},
    '{rtps_pkg::OP_PACKET, 16'h0005, 32'h1234_5678, 32'h0000_1000, 1'b0, 1'b0, '0},
    '{rtps_pkg::OP_STATS,  16'h0000, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0, '0},
    '{rtps_pkg::OP_PACKET, 16'h8005, 32'hA5A5_A5A5, 32'h5A5A_5A5A, 1'b0, 1'b0, '0},
    '{rtps_pkg::OP_PACKET, 16'h7FFF, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0, '0},
    '{rtps_pkg::OP_PACKET, 16'h7FFF, 32'h0000_0000, 32'h8000_0000, 1'b0, 1'b0, '0},
    '{rtps_pkg::OP_STATS,  16'h0000, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b0, '0},
    '{rtps_pkg::OP_STATS,  16'h0000, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0, '0},
    '{rtps_pkg::OP_INIT,   16'd100,  32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0, '0},
    '{rtps_pkg::OP_PACKET, 16'd100,  32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0, '0},
    '{rtps_pkg::OP_PACKET, 16'd101,  32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0, '0},
    '{rtps_pkg::OP_STATS,  16'h0000, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b1,
      '{8'h00, 24'h000000, 32'd101, 32'h0000_0000}},
    '{rtps_pkg::OP_PACKET, 16'd101,  32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0, '0},
    '{rtps_pkg::OP_STATS,  16'h0000, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b1,
      '{8'h00, 24'h000000, 32'd101, 32'h0000_0000}},
    '{rtps_pkg::OP_INIT,   16'h0000, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0, '0},
    '{rtps_pkg::OP_PACKET, 16'h0000, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0, '0},
    '{rtps_pkg::OP_PACKET, 16'h7000, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0, '0},
    '{rtps_pkg::OP_STATS,  16'h0000, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b1,
      '{rtps_pkg::FRACTION_MAX, 24'h006FFF, 32'h0000_7000, 32'h0000_0000}},
    '{rtps_pkg::OP_STATS,  16'h0000, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b1,
      '{8'h00, 24'h006FFF, 32'h0000_7000, 32'h0000_0000}}
  };

  logic clk = 1'b0;
  logic rst;

  rtps_in_if  item_ch ();
  rtps_out_if result_ch ();

  rtp_receiver_stats dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (result_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Stream state of the model.
  logic [15:0] stream_base;
  logic [15:0] top_seq;
  logic [15:0] wraps;
  logic [31:0] rx_count;
  logic [31:0] transit_prev;
  logic [31:0] jitter_q4;
  logic [31:0] expected_mark;
  logic [31:0] received_mark;

  report_t reports_due[$];
  int      mismatches      = 0;
  int      items_in        = 0;
  int      reports_checked = 0;
  int      saturated_seen  = 0;
  int      clamped_seen    = 0;
  int      cycle_count     = 0;
  bit      quiet           = 1'b0;

  function automatic void clear_stream();
    stream_base   = '0;
    top_seq       = '0;
    wraps         = '0;
    rx_count      = '0;
    transit_prev  = '0;
    jitter_q4     = '0;
    expected_mark = '0;
    received_mark = '0;
  endfunction

  // Applies one item to the stream state; returns 1 when it produces a report.
  function automatic bit stream_update(input logic [1:0] op, input logic [15:0] seq,
                                       input logic [31:0] ts, input logic [31:0] arr,
                                       input logic keep, output report_t rep);
    logic [15:0] step;
    logic [31:0] dev, mag, diff, upd, ext, expected, shortfall, exp_int, rec_int, lost;
    logic [63:0] quot;
    rep = '0;
    case (op)
      rtps_pkg::OP_INIT: begin
        clear_stream();
        stream_base = seq;
        top_seq     = seq;
        return 1'b0;
      end
      rtps_pkg::OP_PACKET: begin
        step = seq - top_seq;
        rx_count = rx_count + 32'd1;
        if (!step[15]) begin
          if (seq < top_seq) wraps = wraps + 16'd1;
          top_seq = seq;
        end
        if (rx_count > 32'd1) begin
          dev  = arr - (ts - transit_prev);
          mag  = dev[31] ? (32'd0 - dev) : dev;
          diff = (mag << 4) - jitter_q4;
          upd  = diff + 32'd8;
          jitter_q4 = jitter_q4 + {{4{upd[31]}}, upd[31:4]};
        end
        transit_prev = ts - arr;
        return 1'b0;
      end
      rtps_pkg::OP_STATS: begin
        ext      = {wraps, top_seq};
        expected = ext - {16'd0, stream_base} + 32'd1;
        if (rx_count != 32'd0 && expected > rx_count) begin
          shortfall = expected - rx_count;
          rep.cumulative_lost = (shortfall > {8'd0, rtps_pkg::CUM_LOST_MAX}) ?
                                rtps_pkg::CUM_LOST_MAX : shortfall[23:0];
        end
        exp_int = expected - expected_mark;
        rec_int = rx_count - received_mark;
        if (!keep) begin
          expected_mark = expected;
          received_mark = rx_count;
        end
        lost = exp_int - rec_int;
        if (exp_int != 32'd0 && lost != 32'd0 && !lost[31] && rx_count != 32'd0) begin
          quot = ({32'd0, lost} << 8) / {32'd0, exp_int};
          rep.fraction_lost = (quot > {56'd0, rtps_pkg::FRACTION_MAX}) ?
                              rtps_pkg::FRACTION_MAX : quot[7:0];
        end
        rep.extended_max_seq = ext;
        rep.jitter_estimate  = {4'd0, jitter_q4[31:4]};
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  // Offers one item at a falling edge, waits for the transaction, then updates the model.
  task automatic send_item(input logic [1:0] op, input logic [15:0] seq,
                           input logic [31:0] ts, input logic [31:0] arr,
                           input logic keep, input bit typed, input report_t typed_rep);
    report_t rep;
    int      gap;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      item_ch.valid = 1'b0;
      gap = $urandom_range(1, 18);
      repeat (gap) @(negedge clk);
    end
    item_ch.valid           = 1'b1;
    item_ch.op              = op;
    item_ch.seq_no          = seq;
    item_ch.media_timestamp = ts;
    item_ch.arrival_time    = arr;
    item_ch.keep_interval   = keep;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
    if (stream_update(op, seq, ts, arr, keep, rep))
      reports_due.push_back(typed ? typed_rep : rep);
    if (op != OP_UNUSED) items_in++;
    if (items_in >= QUIET_FROM) quiet = 1'b1;
    @(negedge clk);
  endtask

  // Holds the item channel until every pending report has been taken.
  task automatic hold_until_drained();
    item_ch.valid = 1'b0;
    while (reports_due.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // One random stream. The long-stride variant advances almost half the number
  // space per packet so the wrap count climbs far enough to saturate the loss.
  task automatic run_stream(input int n_items, input bit long_stride);
    logic [15:0] nxt, seq;
    logic [31:0] ts, offset;
    int          span, pick, k;
    nxt    = 16'($urandom);
    ts     = $urandom;
    offset = $urandom;
    span   = 1 << $urandom_range(0, 14);
    if (long_stride || $urandom_range(0, 9) != 0)
      send_item(rtps_pkg::OP_INIT, nxt, $urandom, $urandom, 1'($urandom_range(0, 1)),
                1'b0, '0);
    else
      nxt = top_seq + 16'd1;
    for (k = 0; k < n_items; k++) begin
      pick = $urandom_range(0, 99);
      ts   = ts + (($urandom_range(0, 3) == 0) ? $urandom_range(1, 5000) : 32'd160);
      if (long_stride) begin
        if (k % 40 == 39 || k == n_items - 1) begin
          send_item(rtps_pkg::OP_STATS, 16'($urandom), $urandom, $urandom,
                    1'($urandom_range(0, 1)), 1'b0, '0);
        end else begin
          send_item(rtps_pkg::OP_PACKET, nxt, ts, ts + offset + $urandom_range(0, span),
                    1'($urandom_range(0, 1)), 1'b0, '0);
          nxt = nxt + 16'h7FFF - 16'($urandom_range(0, 3));
        end
      end else if (pick < 60) begin
        send_item(rtps_pkg::OP_PACKET, nxt, ts, ts + offset + $urandom_range(0, span),
                  1'($urandom_range(0, 1)), 1'b0, '0);
        nxt = nxt + 16'd1;
      end else if (pick < 67) begin
        // Late or duplicated packet behind the current highest number.
        seq = nxt - 16'($urandom_range(1, 4));
        send_item(rtps_pkg::OP_PACKET, seq, ts, ts + offset + $urandom_range(0, span),
                  1'($urandom_range(0, 1)), 1'b0, '0);
      end else if (pick < 74) begin
        nxt = nxt + 16'($urandom_range(1, 300));
        send_item(rtps_pkg::OP_PACKET, nxt, ts, ts + offset + $urandom_range(0, span),
                  1'($urandom_range(0, 1)), 1'b0, '0);
        nxt = nxt + 16'd1;
      end else if (pick < 88) begin
        send_item(rtps_pkg::OP_STATS, 16'($urandom), $urandom, $urandom,
                  ($urandom_range(0, 3) == 0), 1'b0, '0);
      end else if (pick < 93) begin
        send_item(rtps_pkg::OP_PACKET, 16'($urandom), $urandom, $urandom,
                  1'($urandom_range(0, 1)), 1'b0, '0);
      end else if (pick < 97) begin
        send_item(OP_UNUSED, 16'($urandom), $urandom, $urandom,
                  1'($urandom_range(0, 1)), 1'b0, '0);
      end else begin
        nxt = 16'($urandom);
        send_item(rtps_pkg::OP_INIT, nxt, $urandom, $urandom, 1'($urandom_range(0, 1)),
                  1'b0, '0);
        nxt = nxt + 16'd1;
      end
    end
  endtask

  // Result side: random stall bursts until the quiet tail of the run.
  initial begin
    int n;
    result_ch.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (quiet || $urandom_range(0, 2) != 0) begin
        result_ch.ready = 1'b1;
        n = $urandom_range(1, 30);
      end else begin
        result_ch.ready = 1'b0;
        n = $urandom_range(1, 18);
      end
      repeat (n) @(negedge clk);
    end
  end

  always @(posedge clk) begin
    report_t want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (reports_due.size() == 0) begin
        $error("report with no stats read pending");
        mismatches++;
      end else begin
        want = reports_due.pop_front();
        reports_checked++;
        if (result_ch.fraction_lost !== want.fraction_lost) begin
          $error("fraction_lost: expected %0d, got %0d",
                 want.fraction_lost, result_ch.fraction_lost);
          mismatches++;
        end
        if (result_ch.cumulative_lost !== want.cumulative_lost) begin
          $error("cumulative_lost: expected %0d, got %0d",
                 want.cumulative_lost, result_ch.cumulative_lost);
          mismatches++;
        end
        if (result_ch.extended_max_seq !== want.extended_max_seq) begin
          $error("extended_max_seq: expected %0h, got %0h",
                 want.extended_max_seq, result_ch.extended_max_seq);
          mismatches++;
        end
        if (result_ch.jitter_estimate !== want.jitter_estimate) begin
          $error("jitter_estimate: expected %0h, got %0h",
                 want.jitter_estimate, result_ch.jitter_estimate);
          mismatches++;
        end
        if (want.cumulative_lost == rtps_pkg::CUM_LOST_MAX) saturated_seen++;
        if (want.fraction_lost == rtps_pkg::FRACTION_MAX) clamped_seen++;
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Timeout after %0d cycles with %0d reports pending",
             cycle_count, reports_due.size());
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    int  i;
    int  streams;
    bit  stride_done;
    rst                     = 1'b1;
    item_ch.valid           = 1'b0;
    item_ch.op              = rtps_pkg::OP_INIT;
    item_ch.seq_no          = '0;
    item_ch.media_timestamp = '0;
    item_ch.arrival_time    = '0;
    item_ch.keep_interval   = 1'b0;
    clear_stream();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    for (i = 0; i < DIRECTED_LEN; i++) begin
      send_item(DIRECTED[i].op, DIRECTED[i].seq, DIRECTED[i].ts, DIRECTED[i].arr,
                DIRECTED[i].keep, DIRECTED[i].typed, DIRECTED[i].rep);
    end
    hold_until_drained();

    streams     = 0;
    stride_done = 1'b0;
    while (items_in < DIRECTED_LEN + RANDOM_ITEMS) begin
      if (!stride_done && streams == 3) begin
        run_stream(STRIDE_ITEMS, 1'b1);
        stride_done = 1'b1;
      end else begin
        run_stream($urandom_range(10, 60), 1'b0);
      end
      streams++;
      if (!quiet && $urandom_range(0, 2) == 0) hold_until_drained();
    end

    item_ch.valid = 1'b0;
    while (reports_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d items in %0d random streams and %0d checked reports.",
             items_in, streams, reports_checked);
    $display("Reports with saturated cumulative loss: %0d, with fraction at maximum: %0d.",
             saturated_seen, clamped_seen);
    if (mismatches == 0 && reports_due.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
